// ===== hdl/checked_integer_text_parser_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the checked integer text parser
// Concurrent checks sampled on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef CHECKED_INTEGER_TEXT_PARSER_CORE_MACROS_SVH
`define CHECKED_INTEGER_TEXT_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/citp_pkg.sv =====
// ---------------------------------------------------------------------------
// citp_pkg
// Item types, scan phases, character codes and character helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package citp_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        parse_ok;
    logic [3:0]  byte_count;
    logic [63:0] value_bits;
  } out_item_t;

  typedef enum logic [6:0] {
    PH_LEAD   = 7'b0000001,
    PH_SIGN   = 7'b0000010,
    PH_ZERO   = 7'b0000100,
    PH_HEXPFX = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_TRAIL  = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_t;

  // Scan state as it stands after the final character of a string
  typedef struct packed {
    phase_t      phase;
    logic        is_negative;
    logic        overflowed;
    logic [63:0] magnitude;
  } scan_snap_t;

  typedef struct packed {
    logic fin_valid;
    logic fin_free;
  } res_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  localparam logic [2:0] VALUE_TYPE_RESET = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_LF) || (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic digit_t digit_of(input logic [7:0] c, input logic hex);
    digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      d.valid = 1'b1;
      d.value = diff[3:0];
    end else if (hex && c >= CH_LO_A && c <= CH_LO_F) begin
      diff = c - CH_LO_A + 8'd10;
      d.valid = 1'b1;
      d.value = diff[3:0];
    end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
      diff = c - CH_UP_A + 8'd10;
      d.valid = 1'b1;
      d.value = diff[3:0];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/citp_scan.sv =====
// ---------------------------------------------------------------------------
// citp_scan
// Per-character scanner: phase tracking and magnitude accumulation.
// ---------------------------------------------------------------------------
`default_nettype none

module citp_scan (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire citp_pkg::in_item_t   in_item,
  output citp_pkg::scan_snap_t      snap
);

  citp_pkg::phase_t phase, phase_next;
  logic             is_negative, is_negative_next;
  logic             hex_mode, hex_mode_next;
  logic [63:0]      magnitude, magnitude_next;
  logic             overflowed, overflowed_next;

  logic [7:0]       c;
  logic             c_space;
  citp_pkg::digit_t dig_dec, dig_hex, dig_cur;
  logic [67:0]      dec_sum;
  logic [63:0]      dec_mag, hex_mag, cur_mag;
  logic             dec_ovf, hex_ovf, cur_ovf;

  assign c       = in_item.char_byte;
  assign c_space = citp_pkg::is_space(c);
  assign dig_dec = citp_pkg::digit_of(c, 1'b0);
  assign dig_hex = citp_pkg::digit_of(c, 1'b1);

  // magnitude * 10 + digit, with any carry beyond 64 bits flagging overflow
  assign dec_sum = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
                   + {64'd0, dig_dec.value};
  assign dec_mag = dec_sum[63:0];
  assign dec_ovf = overflowed || (dec_sum[67:64] != 4'd0);
  assign hex_mag = {magnitude[59:0], dig_hex.value};
  assign hex_ovf = overflowed || (magnitude[63:60] != 4'd0);

  assign dig_cur = hex_mode ? dig_hex : dig_dec;
  assign cur_mag = hex_mode ? hex_mag : dec_mag;
  assign cur_ovf = hex_mode ? hex_ovf : dec_ovf;

  always_comb begin
    phase_next       = phase;
    is_negative_next = is_negative;
    hex_mode_next    = hex_mode;
    magnitude_next   = magnitude;
    overflowed_next  = overflowed;
    unique case (phase) inside
      citp_pkg::PH_LEAD, citp_pkg::PH_SIGN: begin
        if (phase == citp_pkg::PH_LEAD && c_space) begin
          phase_next = phase;
        end else if (phase == citp_pkg::PH_LEAD &&
                     (c == citp_pkg::CH_PLUS || c == citp_pkg::CH_MINUS)) begin
          is_negative_next = (c == citp_pkg::CH_MINUS);
          phase_next       = citp_pkg::PH_SIGN;
        end else if (c == citp_pkg::CH_0) begin
          phase_next = citp_pkg::PH_ZERO;
        end else if (dig_dec.valid) begin
          magnitude_next  = dec_mag;
          overflowed_next = dec_ovf;
          phase_next      = citp_pkg::PH_DIGITS;
        end else begin
          phase_next = citp_pkg::PH_ERROR;
        end
      end
      citp_pkg::PH_ZERO: begin
        // hex_mode is still clear here, so the cur_* terms are decimal
        if (c == citp_pkg::CH_LO_X || c == citp_pkg::CH_UP_X) begin
          hex_mode_next = 1'b1;
          phase_next    = citp_pkg::PH_HEXPFX;
        end else if (c_space) begin
          phase_next = citp_pkg::PH_TRAIL;
        end else if (dig_cur.valid) begin
          magnitude_next  = cur_mag;
          overflowed_next = cur_ovf;
          phase_next      = citp_pkg::PH_DIGITS;
        end else begin
          phase_next = citp_pkg::PH_ERROR;
        end
      end
      citp_pkg::PH_DIGITS: begin
        if (c_space) begin
          phase_next = citp_pkg::PH_TRAIL;
        end else if (dig_cur.valid) begin
          magnitude_next  = cur_mag;
          overflowed_next = cur_ovf;
        end else begin
          phase_next = citp_pkg::PH_ERROR;
        end
      end
      citp_pkg::PH_HEXPFX: begin
        if (dig_hex.valid) begin
          magnitude_next  = hex_mag;
          overflowed_next = hex_ovf;
          phase_next      = citp_pkg::PH_DIGITS;
        end else begin
          phase_next = citp_pkg::PH_ERROR;
        end
      end
      citp_pkg::PH_TRAIL: begin
        if (!c_space) begin
          phase_next = citp_pkg::PH_ERROR;
        end
      end
      default: begin
        phase_next = citp_pkg::PH_ERROR;
      end
    endcase
  end

  assign snap.phase       = phase_next;
  assign snap.is_negative = is_negative_next;
  assign snap.overflowed  = overflowed_next;
  assign snap.magnitude   = magnitude_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= citp_pkg::PH_LEAD;
      is_negative <= 1'b0;
      hex_mode    <= 1'b0;
      magnitude   <= '0;
      overflowed  <= 1'b0;
    end else if (accept) begin
      if (in_item.last_char) begin
        // string done: start the next one clean
        phase       <= citp_pkg::PH_LEAD;
        is_negative <= 1'b0;
        hex_mode    <= 1'b0;
        magnitude   <= '0;
        overflowed  <= 1'b0;
      end else begin
        phase       <= phase_next;
        is_negative <= is_negative_next;
        hex_mode    <= hex_mode_next;
        magnitude   <= magnitude_next;
        overflowed  <= overflowed_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/citp_result.sv =====
// ---------------------------------------------------------------------------
// citp_result
// Holds the final scan state, range-checks it against the type and
// presents the result item from an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module citp_result (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  snap_load,
  input  wire citp_pkg::scan_snap_t  snap,
  input  wire logic [2:0]            value_type,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output citp_pkg::out_item_t        out_item,
  output citp_pkg::res_status_t      status
);

  logic                 fin_valid;
  citp_pkg::scan_snap_t fin;
  logic                 out_load;

  logic [63:0]          mask, maxv, limit, neg_val;
  logic                 type_signed, shape_ok, range_ok, ok;
  logic [3:0]           bytes;
  citp_pkg::out_item_t  res;

  assign out_load        = fin_valid && (!out_valid || out_ready);
  assign status.fin_valid = fin_valid;
  assign status.fin_free  = !fin_valid || out_load;

  always_comb begin
    unique case (value_type[2:1])
      2'd0:    mask = 64'h0000_0000_0000_00FF;
      2'd1:    mask = 64'h0000_0000_0000_FFFF;
      2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  assign bytes       = 4'd1 << value_type[2:1];
  assign type_signed = !value_type[0];
  assign maxv        = type_signed ? (mask >> 1) : mask;
  // negative limit is max + 1; an unsigned negative is rejected by its own term in ok
  assign limit       = fin.is_negative ? (maxv + 64'd1) : maxv;
  assign neg_val     = (~fin.magnitude + 64'd1) & mask;

  assign shape_ok = (fin.phase == citp_pkg::PH_ZERO) ||
                    (fin.phase == citp_pkg::PH_DIGITS) ||
                    (fin.phase == citp_pkg::PH_TRAIL);
  assign range_ok = fin.magnitude <= limit;
  assign ok       = shape_ok && !fin.overflowed &&
                    !(fin.is_negative && !type_signed) && range_ok;

  always_comb begin
    res = '0;
    if (ok) begin
      res.parse_ok   = 1'b1;
      res.byte_count = bytes;
      res.value_bits = fin.is_negative ? neg_val : fin.magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (snap_load) begin
        fin_valid <= 1'b1;
      end else if (out_load) begin
        fin_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      fin <= snap;
    end
    if (out_load) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/checked_integer_text_parser_core.sv =====
// ---------------------------------------------------------------------------
// checked_integer_text_parser_core
// Streaming text-to-integer parser with type range checking.
// ---------------------------------------------------------------------------
// One character is accepted per cycle while in_ready is high, with no gaps
// between strings; in_ready drops while a finished string waits in the
// final-state register and the output register cannot take it. Each
// character updates the scan state in the cycle it is accepted. The flagged
// last character yields one result item: its final scan state is captured,
// then range-checked against value_type into the output register. Characters
// keep flowing while a result waits, if at most one more string is held back.
// value_type is read when the result is formed; write it only when idle.
`default_nettype none

module checked_integer_text_parser_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire citp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output citp_pkg::out_item_t      out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_wr_data
);

`include "checked_integer_text_parser_core_macros.svh"

  logic [2:0]            value_type_reg;
  logic                  in_accept;
  citp_pkg::scan_snap_t  snap;
  citp_pkg::res_status_t status;

  assign in_accept  = in_valid && in_ready;
  assign in_ready   = status.fin_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_type_reg <= citp_pkg::VALUE_TYPE_RESET;
    end else if (cfg_wr_en) begin
      value_type_reg <= cfg_wr_data;
    end
  end

  citp_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .in_item (in_item),
    .snap    (snap)
  );

  citp_result u_result (
    .clk        (clk),
    .rst        (rst),
    .snap_load  (in_accept && in_item.last_char),
    .snap       (snap),
    .value_type (value_type_reg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .status     (status)
  );

  `CITP_ASSERT_NEXT(a_last_fills_fin, in_accept && in_item.last_char, status.fin_valid,
                    "last item did not reach the final stage")
  `CITP_ASSERT_NOW(a_fail_is_zero, out_valid && !out_item.parse_ok,
                   out_item.byte_count == 4'd0 && out_item.value_bits == 64'd0,
                   "failed result carries data")
  `CITP_ASSERT_NOW(a_ok_count, out_valid && out_item.parse_ok,
                   $onehot(out_item.byte_count), "byte count not a power of two")
  `CITP_ASSERT_NOW(a_narrow_upper_zero, out_valid && out_item.byte_count == 4'd1,
                   out_item.value_bits[63:8] == 56'd0, "upper bytes set on 8-bit result")

endmodule

`default_nettype wire
